// ===== rtl/fpfl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Package for the fixed pool free-list allocator: word types, codes, FSM states.
// No dependencies; every other rtl file imports it.
package fpfl_pkg;

   localparam int MAX_BLOCKS_DEFAULT = 256;

   localparam int ADDR_W       = 32;
   localparam int BLOCK_W      = 16;
   localparam int LAST_OFF_W   = 24;
   localparam int FRESH_W      = 25;
   localparam int OVF_W        = 16;
   localparam int STATUS_W     = 3;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 32;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_POOL_BASE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BLOCK_BYTES = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_LAST_OFFSET = 2'd2;

   // reset values of the registers
   localparam logic [ADDR_W-1:0]     POOL_BASE_RESET   = '0;
   localparam logic [BLOCK_W-1:0]    BLOCK_BYTES_RESET = 16'd16;
   localparam logic [LAST_OFF_W-1:0] LAST_OFFSET_RESET = '0;

   // commands
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_POOL_GRANT   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_OVF_GRANT    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FREED        = 3'd2;
   localparam logic [STATUS_W-1:0] ST_OVF_RELEASED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FOREIGN      = 3'd4;
   localparam logic [STATUS_W-1:0] ST_STACK_FULL   = 3'd5;

   localparam logic [OVF_W-1:0] OVF_MAX = '1;

   typedef struct packed {
      logic              command;
      logic [ADDR_W-1:0] free_address;
   } req_word_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   grant_address;
      logic [STATUS_W-1:0] status;
      logic [OVF_W-1:0]    overflow_outstanding;
   } rsp_word_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_POP
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;    // take the request word
      logic commit;     // non-pop step: update state, load result
      logic pop_issue;  // pop: read stack top, drop depth
      logic pop_load;   // pop: load read data into result
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic pop_sel;    // held request is an allocate served from the stack
      logic out_free;   // result register can take a word this cycle
   } dp_status_type;

endpackage : fpfl_pkg
`default_nettype wire

// ===== rtl/fpfl_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Controller FSM of the free-list allocator: sequences capture, commit and pop.
// Depends on fpfl_pkg.
module fpfl_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  fpfl_pkg::dp_status_type dp_status,
   output fpfl_pkg::dp_cmd_type    dp_cmd
);
   import fpfl_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (dp_status.pop_sel) begin
               state_in = ST_POP;
            end else if (dp_status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_POP: begin
            if (dp_status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready        = 1'b0;
      dp_cmd           = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready      = 1'b1;
            dp_cmd.capture = req_valid;
         end
         ST_EXEC: begin
            dp_cmd.pop_issue = dp_status.pop_sel;
            dp_cmd.commit    = !dp_status.pop_sel && dp_status.out_free;
         end
         ST_POP: begin
            dp_cmd.pop_load = dp_status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule : fpfl_ctrl
`default_nettype wire

// ===== rtl/fpfl_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Datapath of the free-list allocator: registers, freed-address stack memory,
// offset and overflow counters, result register. Depends on fpfl_pkg.
module fpfl_dp #(
   parameter int MAX_BLOCKS = fpfl_pkg::MAX_BLOCKS_DEFAULT
) (
   input  wire                                     clock,
   input  wire                                     reset,
   input  fpfl_pkg::req_word_type                  req_word,
   input  wire                                     csr_valid,
   input  wire  [fpfl_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  wire  [fpfl_pkg::CSR_DATA_W-1:0]         csr_wdata,
   output logic                                    rsp_valid,
   input  wire                                     rsp_ready,
   output fpfl_pkg::rsp_word_type                  rsp_word,
   input  fpfl_pkg::dp_cmd_type                    dp_cmd,
   output fpfl_pkg::dp_status_type                 dp_status
);
   import fpfl_pkg::*;

   localparam int DEPTH_W = $clog2(MAX_BLOCKS + 1);
   localparam int SLOT_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(MAX_BLOCKS);

   // configuration
   logic [ADDR_W-1:0]     pool_base_ff;
   logic [BLOCK_W-1:0]    block_bytes_ff;
   logic [LAST_OFF_W-1:0] last_off_ff;

   // allocator state
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [FRESH_W-1:0] fresh_ff, fresh_in;
   logic [OVF_W-1:0]   ovf_ff, ovf_in;
   logic [ADDR_W-1:0]  stack_mem [MAX_BLOCKS];
   logic [ADDR_W-1:0]  rd_data_ff;
   logic               push_en;

   req_word_type req_ff;
   rsp_word_type rsp_ff, rsp_in;
   logic         rsp_valid_ff, rsp_valid_in;

   logic [DEPTH_W-1:0] depth_m1;
   logic [ADDR_W-1:0]  addr_dist;
   logic               fresh_ok;
   logic               in_arena;
   logic               stack_full;
   logic               rsp_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff   <= POOL_BASE_RESET;
         block_bytes_ff <= BLOCK_BYTES_RESET;
         last_off_ff    <= LAST_OFFSET_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_POOL_BASE:   pool_base_ff   <= csr_wdata;
            REG_BLOCK_BYTES: block_bytes_ff <= csr_wdata[BLOCK_W-1:0];
            REG_LAST_OFFSET: last_off_ff    <= csr_wdata[LAST_OFF_W-1:0];
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         req_ff <= req_word;
      end
   end

   assign depth_m1   = depth_ff - 1'b1;
   assign addr_dist  = req_ff.free_address - pool_base_ff;
   assign fresh_ok   = fresh_ff <= {1'b0, last_off_ff};
   assign in_arena   = (req_ff.free_address >= pool_base_ff) &&
                       (addr_dist <= {8'd0, last_off_ff});
   assign stack_full = depth_ff == DEPTH_FULL;
   assign rsp_load   = dp_cmd.commit || dp_cmd.pop_load;

   assign dp_status.pop_sel  = (req_ff.command == CMD_ALLOC) && (depth_ff != '0);
   assign dp_status.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      depth_in = depth_ff;
      fresh_in = fresh_ff;
      ovf_in   = ovf_ff;
      push_en  = 1'b0;
      rsp_in   = rsp_ff;

      if (dp_cmd.pop_issue) begin
         depth_in = depth_m1;
      end

      if (dp_cmd.commit) begin
         rsp_in.grant_address = '0;
         if (req_ff.command == CMD_ALLOC) begin
            if (fresh_ok) begin
               rsp_in.grant_address = pool_base_ff + {7'd0, fresh_ff};
               fresh_in             = fresh_ff + {9'd0, block_bytes_ff};
               rsp_in.status        = ST_POOL_GRANT;
            end else begin
               if (ovf_ff != OVF_MAX) begin
                  ovf_in = ovf_ff + 1'b1;
               end
               rsp_in.status = ST_OVF_GRANT;
            end
         end else begin
            if (in_arena) begin
               if (!stack_full) begin
                  push_en       = 1'b1;
                  depth_in      = depth_ff + 1'b1;
                  rsp_in.status = ST_FREED;
               end else begin
                  rsp_in.status = ST_STACK_FULL;
               end
            end else if (ovf_ff != '0) begin
               ovf_in        = ovf_ff - 1'b1;
               rsp_in.status = ST_OVF_RELEASED;
            end else begin
               rsp_in.status = ST_FOREIGN;
            end
         end
         rsp_in.overflow_outstanding = ovf_in;
      end

      if (dp_cmd.pop_load) begin
         rsp_in.grant_address        = rd_data_ff;
         rsp_in.status               = ST_POOL_GRANT;
         rsp_in.overflow_outstanding = ovf_ff;
      end

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= '0;
         fresh_ff     <= '0;
         ovf_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         depth_ff     <= depth_in;
         fresh_ff     <= fresh_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   // freed-address stack: one write (push) or one registered read (pop) per cycle
   always_ff @(posedge clock) begin
      if (push_en) begin
         stack_mem[depth_ff[SLOT_W-1:0]] <= req_ff.free_address;
      end
      if (dp_cmd.pop_issue) begin
         rd_data_ff <= stack_mem[depth_m1[SLOT_W-1:0]];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule : fpfl_dp
`default_nettype wire

// ===== rtl/fixed_pool_free_list_allocator_top.sv =====
// Fixed-size block pool allocator with a LIFO free list.
// Channels:
//   req_  : valid/ready, one word per request: allocate, or free an address.
//   rsp_  : valid/ready, exactly one word per request, in request order:
//           grant address, status code, overflow allocations outstanding.
//   csr_  : valid/ready register write port, always ready. Index 0 pool
//           base, 1 block size, 2 offset of last block; other indexes are
//           dropped. Write only while no request is in flight.
// Timing:
//   A request is taken in the idle state and worked on in the exec state,
//   which registers the response of frees, fresh-block and overflow
//   allocations once the response register is free. An allocate served from
//   the freed stack reads the stack memory into a register in exec, then
//   loads its response in the pop state. One request is in flight at a time.
// Stall:
//   The response register holds while rsp_ready is low; the block still
//   takes the next request and waits before loading its response.
// Reset:
//   Synchronous, active high. Clears depth, fresh offset, overflow count and
//   response valid, restores register defaults; stack memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none
// Depends on fpfl_pkg, fpfl_ctrl, fpfl_dp.
module fixed_pool_free_list_allocator_top #(
   parameter int MAX_BLOCKS = fpfl_pkg::MAX_BLOCKS_DEFAULT
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_ready,
   input  fpfl_pkg::req_word_type            req_word,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output fpfl_pkg::rsp_word_type            rsp_word,
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire  [fpfl_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire  [fpfl_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import fpfl_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // register writes never stall
   assign csr_ready = 1'b1;

   fpfl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   fpfl_dp #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

endmodule : fixed_pool_free_list_allocator_top
`default_nettype wire

// ===== rtl/fpfl_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Port-level checks on the allocator's response channel, bound to the top level.
// Depends on fpfl_pkg and fixed_pool_free_list_allocator_top.
module fpfl_checker (
   input wire                    clock,
   input wire                    reset,
   input wire                    rsp_valid,
   input wire                    rsp_ready,
   input fpfl_pkg::rsp_word_type rsp_word
);
   import fpfl_pkg::*;

   // a stalled response stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // a stalled response keeps its word
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_word))
      else $error("response word changed while stalled");

   // only defined status codes leave the block
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.status <= ST_STACK_FULL)
      else $error("undefined status code");

   // address only carried on a pool grant
   a_grant_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.status != ST_POOL_GRANT) |-> rsp_word.grant_address == '0)
      else $error("non-zero address on a non-grant response");

   // a release leaves the overflow count below its ceiling
   a_release_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.status == ST_OVF_RELEASED)
      |-> rsp_word.overflow_outstanding != OVF_MAX)
      else $error("overflow count saturated after a release");

endmodule : fpfl_checker

bind fixed_pool_free_list_allocator_top fpfl_checker u_fpfl_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for fixed_pool_free_list_allocator_top: directed script, then random
// traffic under several register settings; each reply word is checked against a local pool
// model or a pinned script word. Depends on fpfl_pkg and the allocator RTL only.
module tb_top;
   import fpfl_pkg::*;

   localparam int POOL_DEPTH      = MAX_BLOCKS_DEFAULT;
   localparam int SETTLE_CYCLES   = 4;
   localparam int CYCLE_LIMIT     = 6000000;
   localparam int ITEMS_PER_PHASE = 135;
   // index 3 decodes to no register; a write there must change nothing
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE = 2'd3;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_word_type           req_word;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_word_type           rsp_word;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   fixed_pool_free_list_allocator_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // ---------------------------------------------------------------------------
   // Pool model: registers, freed stack, fresh-block offset, overflow count
   // ---------------------------------------------------------------------------
   logic [ADDR_W-1:0]     cfg_base  = POOL_BASE_RESET;
   logic [BLOCK_W-1:0]    cfg_bytes = BLOCK_BYTES_RESET;
   logic [LAST_OFF_W-1:0] cfg_last  = LAST_OFFSET_RESET;
   logic [ADDR_W-1:0]     freed_blocks [POOL_DEPTH];
   int unsigned           freed_depth = 0;
   logic [FRESH_W-1:0]    fresh_off   = '0;
   logic [OVF_W-1:0]      ovf_count   = '0;

   rsp_word_type      due_replies [$];   // replies owed by the block, oldest first
   logic [ADDR_W-1:0] held_blocks [$];   // granted pool blocks not yet handed back
   bit                quiet_mode = 1'b0; // no gaps and no stalls while set
   int unsigned       mismatches = 0;
   int unsigned       cycle_count = 0;

   typedef struct {
      bit                     is_csr;
      bit                     pinned;    // expected word typed into the row
      logic [CSR_INDEX_W-1:0] csr_sel;
      logic [ADDR_W-1:0]      value;     // register data, or the address to free
      logic                   cmd;
      rsp_word_type           want;
   } script_row_type;

   script_row_type script [$];

   // One request through the pool; returns the reply word it earns.
   function automatic rsp_word_type step_pool(input logic cmd, input logic [ADDR_W-1:0] addr);
      rsp_word_type r;
      logic [ADDR_W-1:0] from_base;
      r = '0;
      if (cmd == CMD_ALLOC) begin
         if (freed_depth != 0) begin
            freed_depth--;
            r.grant_address = freed_blocks[freed_depth];
            r.status = ST_POOL_GRANT;
         end else if (fresh_off <= {1'b0, cfg_last}) begin
            r.grant_address = cfg_base + ADDR_W'(fresh_off);   // wraps at 32 bits
            fresh_off = fresh_off + FRESH_W'(cfg_bytes);
            r.status = ST_POOL_GRANT;
         end else begin
            if (ovf_count != OVF_MAX) ovf_count++;
            r.status = ST_OVF_GRANT;
         end
      end else begin
         // inside: at or above the base, distance taken without wrap
         from_base = addr - cfg_base;
         if (addr >= cfg_base && from_base <= ADDR_W'(cfg_last)) begin
            if (freed_depth < POOL_DEPTH) begin
               freed_blocks[freed_depth] = addr;
               freed_depth++;
               r.status = ST_FREED;
            end else begin
               r.status = ST_STACK_FULL;
            end
         end else if (ovf_count != 0) begin
            ovf_count--;
            r.status = ST_OVF_RELEASED;
         end else begin
            r.status = ST_FOREIGN;
         end
      end
      r.overflow_outstanding = ovf_count;
      return r;
   endfunction

   function automatic void script_csr(input logic [CSR_INDEX_W-1:0] sel,
                                      input logic [CSR_DATA_W-1:0] data);
      script_row_type row;
      row = '{is_csr: 1'b1, pinned: 1'b0, csr_sel: sel, value: data, cmd: CMD_ALLOC,
              want: '0};
      script.push_back(row);
   endfunction

   function automatic void script_req(input logic cmd, input logic [ADDR_W-1:0] addr,
                                      input logic [ADDR_W-1:0] grant,
                                      input logic [STATUS_W-1:0] st,
                                      input logic [OVF_W-1:0] ovf);
      script_row_type row;
      row = '{is_csr: 1'b0, pinned: 1'b1, csr_sel: REG_POOL_BASE, value: addr, cmd: cmd,
              want: '0};
      row.want.grant_address        = grant;
      row.want.status               = st;
      row.want.overflow_outstanding = ovf;
      script.push_back(row);
   endfunction

   // request row whose reply comes from the pool model
   function automatic void script_chk(input logic cmd, input logic [ADDR_W-1:0] addr);
      script_row_type row;
      row = '{is_csr: 1'b0, pinned: 1'b0, csr_sel: REG_POOL_BASE, value: addr, cmd: cmd,
              want: '0};
      script.push_back(row);
   endfunction

   // Offer one request word; on acceptance run the model and log the reply owed.
   // A pinned word, typed into the script, replaces the modelled one.
   task automatic push_request(input logic cmd, input logic [ADDR_W-1:0] addr,
                               input bit pinned, input rsp_word_type pinned_word);
      int unsigned gap;
      rsp_word_type predicted;
      gap = quiet_mode ? 0 : $urandom_range(0, 8);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_word  <= '{command: cmd, free_address: addr};
      do @(posedge clock); while (req_ready !== 1'b1);
      predicted = step_pool(cmd, addr);
      if (predicted.status == ST_POOL_GRANT) held_blocks.push_back(predicted.grant_address);
      due_replies.push_back(pinned ? pinned_word : predicted);
   endtask

   // Drop valid, wait for every owed reply, then let the pipeline empty.
   task automatic settle_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (due_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] sel,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= sel;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (sel)
         REG_POOL_BASE:   cfg_base  = data;
         REG_BLOCK_BYTES: cfg_bytes = data[BLOCK_W-1:0];
         REG_LAST_OFFSET: cfg_last  = data[LAST_OFF_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic check_reply(input rsp_word_type got);
      rsp_word_type want;
      if (due_replies.size() == 0) begin
         $error("reply word with nothing owed: %h", got);
         mismatches++;
      end else begin
         want = due_replies.pop_front();
         if (got.grant_address !== want.grant_address) begin
            $error("grant_address: expected %h, got %h", want.grant_address, got.grant_address);
            mismatches++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
         end
         if (got.overflow_outstanding !== want.overflow_outstanding) begin
            $error("overflow_outstanding: expected %0d, got %0d",
                   want.overflow_outstanding, got.overflow_outstanding);
            mismatches++;
         end
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Reply side: stall a drawn number of cycles before each word, then take it.
   initial begin : reply_side
      int unsigned stall;
      rsp_ready = 1'b0;
      forever begin
         stall = quiet_mode ? 0 : $urandom_range(0, 8);
         repeat (stall) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
         end
         @(negedge clock);
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1 || rsp_ready !== 1'b1);
         check_reply(rsp_word);
      end
   end

   initial begin : request_side
      int unsigned       ph;
      int unsigned       n;
      int unsigned       pick;
      int unsigned       k;
      longint            span;
      longint            top;
      logic              cmd;
      logic [ADDR_W-1:0] base;
      logic [ADDR_W-1:0] addr;
      logic [BLOCK_W-1:0] bytes;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_word  = '0;
      csr_valid = 1'b0;
      csr_index = REG_POOL_BASE;
      csr_wdata = '0;

      // Reset defaults: a one-block pool at address zero.
      script_req(CMD_ALLOC, 32'h0000_0000, 32'h0000_0000, ST_POOL_GRANT,   16'd0);
      script_req(CMD_ALLOC, 32'hFFFF_FFFF, 32'h0000_0000, ST_OVF_GRANT,    16'd1); // exhausted
      script_req(CMD_FREE,  32'h0000_0000, 32'h0000_0000, ST_FREED,        16'd1);
      script_chk(CMD_ALLOC, 32'h0000_0000);                                         // pop
      script_req(CMD_FREE,  32'h0000_0010, 32'h0000_0000, ST_OVF_RELEASED, 16'd0);
      script_req(CMD_FREE,  32'hFFFF_FFFF, 32'h0000_0000, ST_FOREIGN,      16'd0);
      // Base near the top, stride 8, four blocks; junk above each field must be dropped.
      // Fresh offset is still 16 from the first grant, so the next grants wrap.
      script_csr(REG_POOL_BASE,   32'hFFFF_FFF0);
      script_csr(REG_BLOCK_BYTES, 32'hABCD_0008);
      script_csr(REG_LAST_OFFSET, 32'h5A00_0018);
      script_csr(REG_SPARE,       32'h5A5A_A5A5);
      script_req(CMD_ALLOC, 32'h0000_0000, 32'h0000_0000, ST_POOL_GRANT,   16'd0); // wrapped
      script_chk(CMD_ALLOC, 32'h0000_0000);
      script_chk(CMD_ALLOC, 32'h0000_0000);
      script_chk(CMD_FREE,  32'hFFFF_FFF0);                                         // at base
      script_chk(CMD_FREE,  32'h0000_0008);                                         // below base
      script_chk(CMD_FREE,  32'hFFFF_FFFF);                                         // unaligned
      script_chk(CMD_FREE,  32'hFFFF_FFFF);                                         // double free
      script_req(CMD_FREE,  32'hFFFF_FFEF, 32'h0000_0000, ST_FOREIGN,      16'd0);
      script_chk(CMD_ALLOC, 32'h0000_0000);
      // Largest arena and zero stride; the stack keeps its entries across the change.
      script_csr(REG_POOL_BASE,   32'h0000_1000);
      script_csr(REG_LAST_OFFSET, 32'h00FF_FFFF);
      script_csr(REG_BLOCK_BYTES, 32'h0000_0000);
      script_req(CMD_FREE,  32'h0100_0FFF, 32'h0000_0000, ST_FREED,        16'd0); // last byte
      script_req(CMD_FREE,  32'h0100_1000, 32'h0000_0000, ST_FOREIGN,      16'd0); // one past
      script_chk(CMD_ALLOC, 32'h0000_0000);
      script_chk(CMD_ALLOC, 32'h0000_0000);
      script_chk(CMD_ALLOC, 32'h0000_0000);
      script_chk(CMD_ALLOC, 32'h0000_0000);
      script_chk(CMD_ALLOC, 32'h0000_0000);                                         // no advance
      script_csr(REG_BLOCK_BYTES, 32'h0000_FFFF);
      script_chk(CMD_ALLOC, 32'h0000_0000);
      script_chk(CMD_ALLOC, 32'h0000_0000);

      repeat (6) @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].is_csr) begin
            settle_idle();
            write_csr(script[i].csr_sel, script[i].value);
         end else begin
            push_request(script[i].cmd, script[i].value, script[i].pinned, script[i].want);
         end
      end

      // Fill the freed stack to the brim, knock on it, then drain it again.
      settle_idle();
      write_csr(REG_POOL_BASE,   32'h0000_0000);
      write_csr(REG_BLOCK_BYTES, 32'h0000_0004);
      write_csr(REG_LAST_OFFSET, 32'h0000_03FC);
      while (freed_depth < POOL_DEPTH)
         push_request(CMD_FREE, 32'($urandom_range(0, 32'h3FC)), 1'b0, '0);
      push_request(CMD_FREE, 32'h0000_03FC, 1'b0, '0);
      push_request(CMD_FREE, 32'h0000_0000, 1'b0, '0);
      push_request(CMD_FREE, 32'($urandom_range(0, 32'h3FC)), 1'b0, '0);
      push_request(CMD_FREE, 32'h0000_0400, 1'b0, '0);
      repeat (POOL_DEPTH + 4) push_request(CMD_ALLOC, $urandom, 1'b0, '0);

      // Random traffic. The fresh offset only grows, so each arena but the last one
      // ends just past it, to keep fresh grants and exhaustion within reach.
      for (ph = 0; ph < 6; ph++) begin
         settle_idle();
         case (ph)
            0: begin
               base  = $urandom;
               bytes = BLOCK_W'($urandom_range(1, 64));
               span  = longint'(bytes) * $urandom_range(1, 20);
            end
            1: begin
               base  = '0;
               bytes = 16'd1;
               span  = 7;
            end
            2: begin
               base  = '1;             // only the top byte lies inside
               bytes = BLOCK_W'($urandom_range(1, 4096));
               span  = longint'(bytes) * $urandom_range(4, 30);
            end
            3: begin
               base  = $urandom;
               bytes = '0;
               span  = $urandom_range(0, 64);
            end
            4: begin
               base  = $urandom;
               bytes = '1;
               span  = 'hFFFFFF;
            end
            default: begin
               base  = $urandom;
               bytes = BLOCK_W'($urandom_range(1, 65535));
               span  = 0;
            end
         endcase
         top = longint'(fresh_off) + span;
         if (top > 'hFFFFFF) top = 'hFFFFFF;
         if (ph == 5) top = 0;         // smallest arena: pops and overflow only
         write_csr(REG_POOL_BASE, base);
         write_csr(REG_BLOCK_BYTES, {16'($urandom), bytes});
         write_csr(REG_LAST_OFFSET, {8'($urandom), 24'(top)});

         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n % 40 == 0) quiet_mode = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 49) == 0) settle_idle();
            pick = $urandom_range(0, 99);
            cmd  = CMD_FREE;
            if (pick < 45) begin
               cmd  = CMD_ALLOC;
               addr = $urandom;
            end else if (pick < 80 && held_blocks.size() != 0) begin
               // hand a grant back, mostly the latest one
               k = $urandom_range(0, 1) ? held_blocks.size() - 1
                                        : $urandom_range(0, held_blocks.size() - 1);
               addr = held_blocks[k];
               held_blocks.delete(k);
            end else if (pick < 88) begin
               addr = cfg_base + $urandom_range(0, 32'(cfg_last));
            end else if (pick < 94) begin
               addr = $urandom_range(0, 1)
                      ? cfg_base + 32'(cfg_last) + 32'd1 + $urandom_range(0, 3)
                      : cfg_base - 32'd1 - $urandom_range(0, 3);
            end else begin
               addr = $urandom;
            end
            push_request(cmd, addr, 1'b0, '0);
         end
      end
      quiet_mode = 1'b0;

      // Exhausted one-block pool: a run of overflow grants, a release, more grants.
      settle_idle();
      write_csr(REG_POOL_BASE,   32'h0000_0000);
      write_csr(REG_BLOCK_BYTES, 32'h0000_0010);
      write_csr(REG_LAST_OFFSET, 32'h0000_0000);
      repeat (3) push_request(CMD_ALLOC, $urandom, 1'b0, '0);
      push_request(CMD_FREE, 32'hFFFF_FFFF, 1'b0, '0);
      repeat (2) push_request(CMD_ALLOC, $urandom, 1'b0, '0);

      settle_idle();
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
